FILE: rtl/sidt_pkg.sv
package sidt_pkg;

  localparam int unsigned BinBits   = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned CntW      = 5;
  localparam int unsigned PosW      = 4;
  localparam int unsigned CodeW     = 6;

  localparam logic [CntW-1:0]  CntLast   = CntW'(BinBits - 1);
  localparam logic [CodeW-1:0] DigitBase = 6'd48;
  localparam logic [CodeW-1:0] MinusCode = 6'd45;

  // one converted request: sign and unsigned magnitude
  typedef struct packed {
    logic               neg;
    logic [BinBits-1:0] mag;
  } req_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_DIGIT
  } back_state_t;

endpackage

FILE: rtl/sidt_front.sv
module sidt_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [31:0]     in_value,
  input  sidt_pkg::q_status_t    q_stat,
  output logic                   busy,
  output logic                   q_push,
  output sidt_pkg::req_t         q_wdata
);
  import sidt_pkg::*;

  logic               vld_r, vld_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic               accept;

  // holding register drains into the queue whenever there is room
  assign q_push = vld_r && !q_stat.full;
  assign busy   = vld_r && q_stat.full;
  assign accept = start && !busy;

  always_comb begin
    vld_nxt = accept || (vld_r && !q_push);
    val_nxt = accept ? in_value : val_r;
  end

  // split into sign and magnitude; most negative maps to 2^31
  always_comb begin
    q_wdata.neg = val_r[BinBits-1];
    q_wdata.mag = val_r[BinBits-1] ? (BinBits'(0) - BinBits'(unsigned'(val_r)))
                                   : BinBits'(unsigned'(val_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: rtl/sidt_queue.sv
module sidt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sidt_pkg::req_t      wdata,
  input  logic                pop,
  output sidt_pkg::req_t      rdata,
  output sidt_pkg::q_status_t stat
);
  import sidt_pkg::*;

  req_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    stat.full  = (count_r == 2'd2);
    stat.empty = (count_r == 2'd0);
    rdata      = mem_r[rd_ptr_r];
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

endmodule

FILE: rtl/sidt_back.sv
module sidt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sidt_pkg::q_status_t q_stat,
  input  sidt_pkg::req_t      q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  output logic [5:0]          out_char_code,
  output logic                out_last
);
  import sidt_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [BinBits-1:0] bin_r, bin_nxt;
  bcd_t               bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [PosW-1:0]    pos_r, pos_nxt;
  bcd_t               adj;
  logic [PosW-1:0]    lead;

  // add-3 correction per digit before each shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  // highest nonzero digit, units place when all zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_r[i] != 4'd0) begin
        lead = PosW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (!q_stat.empty) state_nxt = ST_CONV;
      ST_CONV:  if (cnt_r == CntLast) state_nxt = ST_FIND;
      ST_FIND:  state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      ST_SIGN:  state_nxt = ST_DIGIT;
      ST_DIGIT: if (pos_r == '0) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    case (state_r)
      ST_IDLE: begin
        bin_nxt = q_rdata.mag;
        neg_nxt = q_rdata.neg;
        bcd_nxt = '0;
        cnt_nxt = '0;
      end
      ST_CONV: begin
        bin_nxt = {bin_r[BinBits-2:0], 1'b0};
        bcd_nxt = bcd_t'({adj[NumDigits-1][2:0], adj[NumDigits-2:0], bin_r[BinBits-1]});
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_FIND:  pos_nxt = lead;
      ST_DIGIT: pos_nxt = pos_r - 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    q_pop         = (state_r == ST_IDLE) && !q_stat.empty;
    out_valid     = (state_r == ST_SIGN) || (state_r == ST_DIGIT);
    out_char_code = (state_r == ST_SIGN) ? MinusCode : (DigitBase + {2'b00, bcd_r[pos_r]});
    out_last      = (state_r == ST_DIGIT) && (pos_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
  end

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("character after end of run");

  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SIGN |=> state_r == ST_DIGIT && out_valid)
    else $error("minus sign not followed by a digit");

  a_pop_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_CONV && cnt_r == '0)
    else $error("pop did not start a conversion");

endmodule

FILE: rtl/signed_int_to_decimal_text.sv
// path: input register, queue, then the back end pops, converts, finds the lead digit, emits
// each request runs the 32-step shift-and-add-3 binary-to-bcd loop in the back end,
//   then emits 1..11 characters
// a two-entry queue plus the input register buffer up to three requests
// reset: synchronous active-low rst_n clears control state, no results pending
// results cannot be stalled: each character shows for one cycle with out_valid
module signed_int_to_decimal_text (
  input  logic               clk,
  input  logic               rst_n,
  // request side
  input  logic               start,
  input  logic signed [31:0] in_value,
  output logic               busy,
  // character stream
  output logic               out_valid,
  output logic [5:0]         out_char_code,
  output logic               out_last
);
  import sidt_pkg::*;

  // front to queue
  logic      q_push;
  req_t      q_wdata;
  // queue to back
  logic      q_pop;
  req_t      q_rdata;
  q_status_t q_stat;

  // front: takes a request, splits sign from magnitude
  sidt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_value (in_value),
    .q_stat   (q_stat),
    .busy     (busy),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // short queue lets the front keep taking requests while the back converts
  sidt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: binary to bcd, then emits a minus sign for a negative value and
  // the digits most significant first, skipping leading zeros
  sidt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

FILE: test/tb_signed_int_to_decimal_text.sv
module tb_signed_int_to_decimal_text;
  import sidt_pkg::*;

  // decimal radix used by the text predictor
  localparam int unsigned Radix = 10;
  // cycles without any request or character accepted before the run is abandoned
  localparam int unsigned StallLimit = 2000;
  // quiet time after the last character, well past the first-character latency
  localparam int unsigned DrainCycles = 80;
  // mismatches printed in full, later ones only counted
  localparam int unsigned MaxReports = 10;

  // one expected character of a run
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic signed [31:0] in_value;
  logic busy;
  logic out_valid;
  logic [CodeW-1:0] out_char_code;
  logic out_last;

  // characters predicted but not yet seen, oldest first
  text_char_t pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  // set while the sender runs with no gaps at all
  bit no_gaps = 1'b0;

  signed_int_to_decimal_text DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_value     (in_value),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  // 10-unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decimal text of one value: optional minus, then digits msd first,
  // last flag on the final digit; the most negative value wraps to 2^31
  function automatic void predict_text(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digit_buf [NumDigits];
    text_char_t  c;
    int          n;
    int          i;
    mag = v[31] ? (32'd0 - v) : v;
    n = 0;
    do begin
      digit_buf[n] = 4'(mag % Radix);
      mag = mag / Radix;
      n++;
    end while (mag != 0);
    if (v[31]) begin
      c.code = MinusCode;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (i = n - 1; i >= 0; i--) begin
      c.code = DigitBase + CodeW'(digit_buf[i]);
      c.last = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // request accepted: predict its characters at the same edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_text(in_value);
    end
  end

  // every strobed character must match the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < MaxReports) begin
          $display("unexpected char: code %0d last %0b", out_char_code, out_last);
        end
      end else begin
        if (out_char_code !== pending_chars[0].code || out_last !== pending_chars[0].last) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MaxReports) begin
            $display("char mismatch: expected code %0d last %0b, got code %0d last %0b",
                     pending_chars[0].code, pending_chars[0].last, out_char_code, out_last);
          end
        end
        void'(pending_chars.pop_front());
      end
    end
  end

  // watchdog: restart the count whenever a request or a character moves
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb_signed_int_to_decimal_text: done, errors");
      $finish;
    end
  end

  // drop start for a while; short gaps mostly, now and then a longer one
  task automatic hold_off();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // present one request and wait for the edge that takes it;
  // start stays high so the next request can follow with no gap
  task automatic send_value(input logic signed [31:0] v);
    if (!no_gaps && $urandom_range(0, 99) < 16) begin
      hold_off();
    end
    in_value <= v;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // random magnitude with exactly n decimal digits (1..10), random sign
  function automatic logic signed [31:0] value_of_length(input int unsigned n);
    longint lo;
    longint hi;
    longint mag;
    int     k;
    lo = 1;
    for (k = 1; k < n; k++) lo = lo * Radix;
    hi = lo * Radix - 1;
    if (n == 1) lo = 0;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
    return $urandom_range(0, 1) ? -32'(mag) : 32'(mag);
  endfunction

  // zero, single digits, powers of ten and their neighbors, both extremes
  task automatic test_corner_values();
    logic signed [31:0] corners [] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
      32'sd99, 32'sd100, -32'sd100, 32'sd12345, -32'sd54321,
      32'sd999999999, 32'sd1000000000, -32'sd999999999, -32'sd1000000000,
      32'sd1234567890, -32'sd1234567890, 32'sd2147483646, 32'sd2147483647,
      -32'sd2147483647, 32'sh8000_0000
    };
    foreach (corners[i]) send_value(corners[i]);
  endtask

  // random run lengths and signs with random digits
  task automatic test_random_lengths();
    repeat (200) send_value(value_of_length($urandom_range(1, 10)));
  endtask

  // back-to-back requests, no gaps: keeps the queue full
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (80) begin
      if ($urandom_range(0, 1)) send_value(value_of_length($urandom_range(1, 10)));
      else send_value($urandom);
    end
    no_gaps = 1'b0;
  endtask

  // full-width random words: every input bit both ways
  task automatic test_random_words();
    repeat (130) send_value($urandom);
  endtask

  initial begin
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_values();
    test_random_lengths();
    test_back_to_back();
    test_random_words();
    start <= 1'b0;

    // let every predicted character come out, then watch for strays
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("tb_signed_int_to_decimal_text: done, clean");
    end else begin
      $display("tb_signed_int_to_decimal_text: done, errors");
    end
    $finish;
  end

endmodule
